// ----- rtl/ihls_color_threshold_macros.svh -----
// ---------------------------------------------------------------------------
// ihls_color_threshold_macros.svh
// Assertion macros used by the checker file ihls_checker.sv.
// ---------------------------------------------------------------------------
`ifndef IHLS_COLOR_THRESHOLD_MACROS_SVH
`define IHLS_COLOR_THRESHOLD_MACROS_SVH

// implication checked on every clock edge outside reset
`define IHLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define IHLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ihls_pkg.sv -----
// ---------------------------------------------------------------------------
// ihls_pkg
// Types and constants for the improved-HLS pixel converter.
// ---------------------------------------------------------------------------
package ihls_pkg;

   localparam int FracBits = 16;
   localparam int Steps    = 16;
   // vector width: |x| grows to about 1.65*510*2^16 < 2^26
   localparam int VecW     = 28;
   // angle width: signed, full circle is 255*2^16 < 2^24
   localparam int AngW     = 26;

   localparam logic signed [AngW-1:0] FullTurn = AngW'(255 <<< FracBits);
   localparam logic signed [AngW-1:0] HalfTurn = AngW'(255 <<< (FracBits - 1));
   localparam logic [17:0] Sqrt3Fix = 18'd113512;

   localparam logic [1:0] CsrMode  = 2'd0;
   localparam logic [1:0] CsrUpper = 2'd1;
   localparam logic [1:0] CsrLower = 2'd2;
   localparam logic [1:0] CsrFloor = 2'd3;

   // cordic angle table in hue units with 16 fraction bits
   function automatic logic signed [AngW-1:0] atan_unit(input logic [3:0] idx);
      logic signed [AngW-1:0] v;
      begin
         case (idx)
            4'd0:    v = AngW'(2088960);
            4'd1:    v = AngW'(1233185);
            4'd2:    v = AngW'(651581);
            4'd3:    v = AngW'(330753);
            4'd4:    v = AngW'(166018);
            4'd5:    v = AngW'(83090);
            4'd6:    v = AngW'(41555);
            4'd7:    v = AngW'(20779);
            4'd8:    v = AngW'(10390);
            4'd9:    v = AngW'(5195);
            4'd10:   v = AngW'(2597);
            4'd11:   v = AngW'(1299);
            4'd12:   v = AngW'(649);
            4'd13:   v = AngW'(325);
            4'd14:   v = AngW'(162);
            default: v = AngW'(81);
         endcase
         return v;
      end
   endfunction

   // data handed from cell to cell
   typedef struct packed {
      logic                   valid;
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] z;
      logic                   rotate;   // run cordic update in this cell
      logic [7:0]             sat;
      logic [7:0]             lum;
   } cell_data_type;

endpackage

// ----- rtl/ihls_cell.sv -----
// ---------------------------------------------------------------------------
// ihls_cell
// One vectoring CORDIC step with a pipeline register.
// ---------------------------------------------------------------------------
module ihls_cell #(
   parameter int Index = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ihls_pkg::cell_data_type in_data,
   output ihls_pkg::cell_data_type out_data
);
   import ihls_pkg::*;

   cell_data_type data_ff, data_in;
   logic signed [VecW-1:0] xs, ys;

   // rotate toward the x axis, accumulate angle
   always_comb begin
      data_in = in_data;
      xs = in_data.x >>> Index;
      ys = in_data.y >>> Index;
      if (in_data.rotate) begin
         if (!in_data.y[VecW-1]) begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + atan_unit(4'(Index));
         end else begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - atan_unit(4'(Index));
         end
      end
   end

   // advance when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff.valid <= data_in.valid;
      end
      if (advance) begin
         data_ff.x      <= data_in.x;
         data_ff.y      <= data_in.y;
         data_ff.z      <= data_in.z;
         data_ff.rotate <= data_in.rotate;
         data_ff.sat    <= data_in.sat;
         data_ff.lum    <= data_in.lum;
      end
   end

   assign out_data = data_ff;
endmodule

// ----- rtl/ihls_front.sv -----
// ---------------------------------------------------------------------------
// ihls_front
// Forms saturation, luminance and the starting cordic vector of a pixel.
// ---------------------------------------------------------------------------
module ihls_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [7:0]              red,
   input  logic [7:0]              green,
   input  logic [7:0]              blue,
   output ihls_pkg::cell_data_type out_data
);
   import ihls_pkg::*;

   cell_data_type data_ff, data_in;
   logic [7:0] hi, lo;
   logic [17:0] wsum;
   logic [7:0] lum_q;
   logic signed [10:0] dx;
   logic signed [8:0]  dy;
   logic signed [VecW-1:0] x0, y0;
   logic [VecW-1:0] prod;

   always_comb begin
      // saturation from max and min
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi)  hi = blue;
      if (green < lo) lo = green;
      if (blue < lo)  lo = blue;
      // luminance: wsum / 1000 by reciprocal, wsum < 2^18, product < 2^41
      wsum  = 18'(18'd210 * red) + 18'(18'd715 * green) + 18'(18'd72 * blue);
      lum_q = 8'((42'(wsum) * 42'd4294968) >> 32);
      // vector before scaling
      dx = 11'(2 * $signed({3'b0, red})) - 11'($signed({1'b0, green}))
         - 11'($signed({1'b0, blue}));
      dy = $signed({1'b0, green}) - $signed({1'b0, blue});
      x0 = VecW'(dx) <<< FracBits;
      prod = VecW'($signed(VecW'(dy)) * $signed({1'b0, Sqrt3Fix}));
      y0 = $signed(prod);

      data_in.valid  = in_valid;
      data_in.sat    = hi - lo;
      data_in.lum    = lum_q;
      data_in.rotate = (dy != 9'sd0);
      // gray or on the axis: angle fixed, no rotation
      if (dy == 9'sd0) begin
         data_in.x = x0;
         data_in.y = y0;
         data_in.z = dx[10] ? HalfTurn : '0;
      end else if (dx[10]) begin
         data_in.x = -x0;
         data_in.y = -y0;
         data_in.z = HalfTurn;
      end else begin
         data_in.x = x0;
         data_in.y = y0;
         data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff.valid <= data_in.valid;
      end
      if (advance) begin
         data_ff.x      <= data_in.x;
         data_ff.y      <= data_in.y;
         data_ff.z      <= data_in.z;
         data_ff.rotate <= data_in.rotate;
         data_ff.sat    <= data_in.sat;
         data_ff.lum    <= data_in.lum;
      end
   end

   assign out_data = data_ff;
endmodule

// ----- rtl/ihls_color_threshold.sv -----
// Improved-HLS converter with hue/saturation mask, one pixel per clock
// while rsp is not stalled. Pipeline: front stage, 16 CORDIC cells and
// output stage, each registered. The chain advances as a whole; a stalled
// output holds the whole chain.
// Reset (synchronous) empties the chain and loads mode 1, upper 15,
// lower 240, floor 150.
// ---------------------------------------------------------------------------
// ihls_color_threshold
// Top level: config registers, cell chain and mask test.
// ---------------------------------------------------------------------------
module ihls_color_threshold (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_luminance,
   output logic [7:0] rsp_hue,
   output logic       rsp_mask,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import ihls_pkg::*;

   logic mode_ff;
   logic [7:0] upper_ff, lower_ff, floor_ff;
   logic advance;
   cell_data_type chain [0:Steps];
   logic signed [AngW-1:0] z_fix;
   logic [7:0] hue_c;
   logic hue_ok;
   logic out_valid_ff;
   logic [7:0] sat_ff, lum_ff, hue_ff;
   logic mask_ff;

   // config registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         upper_ff <= 8'd15;
         lower_ff <= 8'd240;
         floor_ff <= 8'd150;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrMode:  mode_ff  <= csr_data[0];
            CsrUpper: upper_ff <= csr_data;
            CsrLower: lower_ff <= csr_data;
            CsrFloor: floor_ff <= csr_data;
            default:  ;
         endcase
      end
   end

   // chain moves unless the output holds a stalled item
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   ihls_front u_front (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .red(req_red), .green(req_green), .blue(req_blue), .out_data(chain[0])
   );

   for (genvar i = 0; i < Steps; i++) begin : g_cell
      ihls_cell #(.Index(i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .in_data(chain[i]), .out_data(chain[i+1])
      );
   end

   // wrap angle into one turn and apply the mask test
   always_comb begin
      z_fix = chain[Steps].z;
      if (z_fix < 0)              z_fix = z_fix + FullTurn;
      else if (z_fix >= FullTurn) z_fix = z_fix - FullTurn;
      hue_c = z_fix[FracBits +: 8];
      if (!mode_ff) hue_ok = (hue_c > lower_ff) && (hue_c < upper_ff);
      else          hue_ok = (hue_c > lower_ff) || (hue_c < upper_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[Steps].valid;
      end
      if (advance) begin
         sat_ff  <= chain[Steps].sat;
         lum_ff  <= chain[Steps].lum;
         hue_ff  <= hue_c;
         mask_ff <= hue_ok && (chain[Steps].sat > floor_ff);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_luminance  = lum_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_mask       = mask_ff;
endmodule

// ----- rtl/ihls_checker.sv -----
// ---------------------------------------------------------------------------
// ihls_checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "ihls_color_threshold_macros.svh"

module ihls_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_saturation,
   input logic [7:0] rsp_hue,
   input logic       rsp_mask
);
   // a stalled result holds
   `IHLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hue), "stalled rsp item changed")
   // input stalls only behind a stalled result
   `IHLS_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "req stalled without rsp stall")
   // mask needs saturation above zero
   `IHLS_ASSERT_IMP(a_mask_sat, clock, reset, rsp_valid && rsp_mask, rsp_saturation != 8'd0, "mask set on gray pixel")
   // gray pixels have hue zero
   `IHLS_ASSERT_IMP(a_gray_hue, clock, reset, rsp_valid && rsp_saturation == 8'd0, rsp_hue == 8'd0, "gray pixel with nonzero hue")
endmodule

bind ihls_color_threshold ihls_checker u_ihls_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_saturation(rsp_saturation),
   .rsp_hue(rsp_hue), .rsp_mask(rsp_mask)
);
